// ----- src/boxblur_pkg.sv -----
package boxblur_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int HEIGHT_LIMIT       = 1024;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Output queue depth; also bounds the results that may be in flight.
  localparam int FIFO_DEPTH = 8;

  // Quotients are formed as (num * recip) >> RECIP_SHIFT.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 16;
  localparam int NUM_W       = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            is_pad;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } pix_out_t;

  // Per-item control that travels alongside the pixel through the pipeline.
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic fend;
  } edge_ctl_t;

  // Reciprocal of twice the neighbourhood size, scaled by 2^RECIP_SHIFT and
  // rounded up. Exact for every numerator the averaging stage can produce.
  function automatic logic [RECIP_W-1:0] avg_recip(input logic [3:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10923;
      4'd4:    m = 16'd8192;
      4'd6:    m = 16'd5462;
      4'd9:    m = 16'd3641;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- src/boxblur_ram.sv -----
module boxblur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-first: a read and a write to the same address return the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/boxblur_lines.sv -----
module boxblur_lines #(
  parameter int MAX_WIDTH = boxblur_pkg::MAX_WIDTH_DEFAULT,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         acc_valid,
  input  logic [AW-1:0]                                acc_col,
  input  logic [boxblur_pkg::PIX_W-1:0]                acc_pix,
  input  boxblur_pkg::edge_ctl_t                       acc_ctl,
  output logic [8:0][boxblur_pkg::PIX_W-1:0]           win,
  output boxblur_pkg::edge_ctl_t                       win_ctl
);

  localparam int PW = boxblur_pkg::PIX_W;

  logic                   s1_valid;
  logic [AW-1:0]          s1_col;
  logic [PW-1:0]          s1_pix;
  boxblur_pkg::edge_ctl_t s1_ctl;

  logic                   byp_hit;
  logic [PW-1:0]          byp_upper;
  logic [PW-1:0]          byp_middle;

  logic [2*PW-1:0]        rd_data;
  logic [PW-1:0]          above;
  logic [PW-1:0]          mid;

  // Upper row in the high half, middle row in the low half of one word.
  boxblur_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({mid, s1_pix}),
    .rd_en   (acc_valid),
    .rd_addr (acc_col),
    .rd_data (rd_data)
  );

  // A read issued in the same cycle as a write to that column sees stale
  // data, so the written values are forwarded instead.
  assign above = byp_hit ? byp_upper  : rd_data[2*PW-1:PW];
  assign mid   = byp_hit ? byp_middle : rd_data[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
      win_ctl  <= '0;
      win      <= '0;
    end else begin
      s1_valid <= acc_valid;
      byp_hit  <= s1_valid && acc_valid && (acc_col == s1_col);
      win_ctl  <= s1_valid ? s1_ctl : '0;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= above;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= mid;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_col     <= acc_col;
    s1_pix     <= acc_pix;
    s1_ctl     <= acc_ctl;
    byp_upper  <= mid;
    byp_middle <= s1_pix;
  end

endmodule

// ----- src/boxblur_avg.sv -----
module boxblur_avg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [8:0][boxblur_pkg::PIX_W-1:0]   win,
  input  boxblur_pkg::edge_ctl_t               win_ctl,
  output logic                                 res_valid,
  output boxblur_pkg::pix_out_t                res
);

  localparam int CW  = boxblur_pkg::CH_W;
  localparam int NW  = boxblur_pkg::NUM_W;
  localparam int RW  = boxblur_pkg::RECIP_W;
  localparam int PRW = NW + RW;

  logic [1:0]             rows;
  logic [1:0]             cols;
  logic [2:0][2:0][9:0]   row_sum_next;

  logic                   a_valid;
  logic                   a_fend;
  logic [3:0]             a_count;
  logic [2:0][2:0][9:0]   a_row_sum;

  logic                   b_valid;
  logic                   b_fend;
  logic [2:0][NW-1:0]     b_num;
  logic [RW-1:0]          b_recip;

  logic [2:0][PRW-1:0]    prod;

  always_comb begin
    logic       row_on;
    logic [9:0] v0;
    logic [9:0] v1;
    logic [9:0] v2;
    rows = (win_ctl.top && win_ctl.bottom) ? 2'd1 :
           (win_ctl.top || win_ctl.bottom) ? 2'd2 : 2'd3;
    cols = (win_ctl.left && win_ctl.right) ? 2'd1 :
           (win_ctl.left || win_ctl.right) ? 2'd2 : 2'd3;
    for (int r = 0; r < 3; r++) begin
      row_on = !((r == 0) && win_ctl.top) && !((r == 2) && win_ctl.bottom);
      for (int ch = 0; ch < 3; ch++) begin
        v0 = win_ctl.left  ? 10'd0 : 10'(win[r*3][(2-ch)*CW +: CW]);
        v1 = 10'(win[r*3+1][(2-ch)*CW +: CW]);
        v2 = win_ctl.right ? 10'd0 : 10'(win[r*3+2][(2-ch)*CW +: CW]);
        row_sum_next[r][ch] = row_on ? (v0 + v1 + v2) : 10'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= win_ctl.emit;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [11:0] total;
    a_fend    <= win_ctl.fend;
    a_count   <= {2'b00, rows} * {2'b00, cols};
    a_row_sum <= row_sum_next;
    b_fend    <= a_fend;
    b_recip   <= boxblur_pkg::avg_recip(a_count);
    for (int ch = 0; ch < 3; ch++) begin
      total = 12'(a_row_sum[0][ch]) + 12'(a_row_sum[1][ch]) + 12'(a_row_sum[2][ch]);
      // Twice the sum plus the count, so that halves round up.
      b_num[ch] <= {total, 1'b0} + NW'(a_count);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PRW'(b_num[ch]) * PRW'(b_recip);
    end
  end

  assign res_valid     = b_valid;
  assign res.out_red   = prod[0][boxblur_pkg::RECIP_SHIFT +: CW];
  assign res.out_green = prod[1][boxblur_pkg::RECIP_SHIFT +: CW];
  assign res.out_blue  = prod[2][boxblur_pkg::RECIP_SHIFT +: CW];
  assign res.frame_end = b_fend;

endmodule

// ----- src/boxblur_fifo.sv -----
module boxblur_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [CW-1:0]    count
);

  logic [DEPTH-1:0][WIDTH-1:0] mem;
  logic [PW-1:0]               wr_ptr;
  logic [PW-1:0]               rd_ptr;
  logic                        do_pop;

  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/box_blur_3x3_edge_clamped.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_data  (pix_in_t)
// out      output     out_valid/out_ready  out_data (pix_out_t)
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel is taken per clock while in_ready is high; a result enters the output
// queue after the transaction that releases it, through the line-buffer read and
// the sum, divide pipeline.
// Input is held off while queued plus in-flight results fill the eight-entry
// output queue, and while a configuration write is offered. Configuration is
// always accepted.
// Reset clears control state at once; the line buffers need no clearing pass.
module box_blur_3x3_edge_clamped #(
  parameter int MAX_WIDTH = boxblur_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  boxblur_pkg::pix_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output boxblur_pkg::pix_out_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [boxblur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [boxblur_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = boxblur_pkg::FIFO_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OW    = $bits(boxblur_pkg::pix_out_t);
  localparam int DW    = boxblur_pkg::CFG_DATA_W;
  localparam int WIDTH_RESET =
    (boxblur_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : boxblur_pkg::FRAME_WIDTH_RESET;

  logic [AW-1:0]                   width_last;
  logic [9:0]                      height_last;
  logic [AW-1:0]                   width_cfg_last;
  logic [9:0]                      height_cfg_last;

  logic [AW-1:0]                   in_col;
  logic [10:0]                     in_row;
  logic [AW-1:0]                   out_col;
  logic [9:0]                      out_row;

  logic [CNT_W-1:0]                pending;
  logic [CNT_W-1:0]                pending_next;
  logic [CNT_W-1:0]                fifo_count;

  logic                            accept;
  logic                            cfg_wr;
  logic                            cfg_hit;
  logic [boxblur_pkg::PIX_W-1:0]   acc_pix;
  boxblur_pkg::edge_ctl_t          acc_ctl;

  logic [8:0][boxblur_pkg::PIX_W-1:0] win;
  boxblur_pkg::edge_ctl_t             win_ctl;
  logic                               res_valid;
  boxblur_pkg::pix_out_t              res;
  logic [OW-1:0]                      fifo_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == boxblur_pkg::REG_FRAME_WIDTH) ||
                     (cfg_index == boxblur_pkg::REG_FRAME_HEIGHT);

  // Dimensions are kept as their last index, clamped into range.
  always_comb begin
    if (cfg_data == '0) begin
      width_cfg_last = '0;
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      width_cfg_last = AW'(MAX_WIDTH - 1);
    end else begin
      width_cfg_last = AW'(cfg_data - DW'(1));
    end
    if (cfg_data == '0) begin
      height_cfg_last = '0;
    end else if (cfg_data > DW'(boxblur_pkg::HEIGHT_LIMIT)) begin
      height_cfg_last = 10'(boxblur_pkg::HEIGHT_LIMIT - 1);
    end else begin
      height_cfg_last = 10'(cfg_data - DW'(1));
    end
  end

  // A pixel never shares a cycle with a configuration write, so the write's
  // restart cannot swallow the pixel's position update.
  assign in_ready = !cfg_valid &&
                    (({1'b0, fifo_count} + {1'b0, pending}) < (CNT_W + 1)'(DEPTH));
  assign accept   = in_valid && in_ready;

  assign acc_pix = in_data.is_pad ? '0 :
                   {in_data.in_red, in_data.in_green, in_data.in_blue};

  // The output position trails the input by one row and one pixel.
  always_comb begin
    acc_ctl.emit   = (in_row >= 11'd2) || ((in_row == 11'd1) && (in_col != '0));
    acc_ctl.left   = (out_col == '0);
    acc_ctl.right  = (out_col == width_last);
    acc_ctl.top    = (out_row == '0);
    acc_ctl.bottom = (out_row == height_last);
    acc_ctl.fend   = acc_ctl.bottom && acc_ctl.right;
  end

  always_comb begin
    pending_next = pending;
    if (accept && acc_ctl.emit && !res_valid) begin
      pending_next = pending + 1'b1;
    end else if (!(accept && acc_ctl.emit) && res_valid) begin
      pending_next = pending - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= AW'(WIDTH_RESET - 1);
      height_last <= 10'(boxblur_pkg::FRAME_HEIGHT_RESET - 1);
      in_col      <= '0;
      in_row      <= '0;
      out_col     <= '0;
      out_row     <= '0;
      pending     <= '0;
    end else begin
      pending <= pending_next;
      if (cfg_wr) begin
        case (cfg_index)
          boxblur_pkg::REG_FRAME_WIDTH:  width_last  <= width_cfg_last;
          boxblur_pkg::REG_FRAME_HEIGHT: height_last <= height_cfg_last;
          default: ;
        endcase
        if (cfg_hit) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end
      end else if (accept) begin
        if (in_col == width_last) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (acc_ctl.emit) begin
          if (acc_ctl.right) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
          // The last pixel of the frame restarts every position counter.
          if (acc_ctl.fend) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end
        end
      end
    end
  end

  boxblur_lines #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk       (clk),
    .rst       (rst),
    .acc_valid (accept),
    .acc_col   (in_col),
    .acc_pix   (acc_pix),
    .acc_ctl   (acc_ctl),
    .win       (win),
    .win_ctl   (win_ctl)
  );

  boxblur_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .win_ctl   (win_ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  boxblur_fifo #(
    .WIDTH (OW),
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_ready),
    .pop_valid (out_valid),
    .pop_data  (fifo_data),
    .count     (fifo_count)
  );

  assign out_data = boxblur_pkg::pix_out_t'(fifo_data);

endmodule
